@@ sv/ptsr_pkg.sv @@
package ptsr_pkg;

  // Sizes of the parent table and of the route walk
  localparam int TABLE_DEPTH = 32;
  localparam int MAX_HOPS    = 16;
  localparam int ADDR_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 4;
  localparam int TIDX_W      = $clog2(TABLE_DEPTH);
  localparam int TCNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int HIDX_W      = $clog2(MAX_HOPS);
  localparam int HCNT_W      = $clog2(MAX_HOPS + 1);

  localparam logic [ADDR_W-1:0] SINK_RESET = 8'h01;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BROKEN   = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ACCEPT = 3'd1,
    OP_ADD    = 3'd2,
    OP_LOOK   = 3'd3,
    OP_CHECK  = 3'd4,
    OP_EMIT   = 3'd5
  } op_t;

  // Branch condition of one microcode step
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_ACTION    = 3'd1,
    C_HIT       = 3'd2,
    C_MORE      = 3'd3,
    C_OK        = 3'd4,
    C_MORE_EMIT = 3'd5
  } cond_t;

  // Microcode addresses
  typedef enum logic [2:0] {
    P_IDLE   = 3'd0,
    P_ADD    = 3'd1,
    P_LOOK   = 3'd2,
    P_CHECK  = 3'd3,
    P_SELECT = 3'd4,
    P_EMIT   = 3'd5
  } step_t;

  typedef struct packed {
    op_t   op;
    logic  wait_in;
    logic  use_out;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctrl_t;

  // Control store: one word per step, branch to tgt_t when cond holds
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      P_IDLE:   w = '{OP_ACCEPT, 1'b1, 1'b0, C_ACTION,    P_LOOK, P_ADD};
      P_ADD:    w = '{OP_ADD,    1'b0, 1'b1, C_ALWAYS,    P_IDLE, P_IDLE};
      P_LOOK:   w = '{OP_LOOK,   1'b0, 1'b1, C_HIT,       P_CHECK, P_IDLE};
      P_CHECK:  w = '{OP_CHECK,  1'b0, 1'b1, C_MORE,      P_LOOK, P_SELECT};
      P_SELECT: w = '{OP_NONE,   1'b0, 1'b0, C_OK,        P_EMIT, P_IDLE};
      P_EMIT:   w = '{OP_EMIT,   1'b0, 1'b1, C_MORE_EMIT, P_EMIT, P_IDLE};
      default:  w = '{OP_NONE,   1'b0, 1'b0, C_ALWAYS,    P_IDLE, P_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ sv/ptsr_ram.sv @@
module ptsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/parent_table_source_route_unit.sv @@
// Parent table and source-route builder.
// Input channel (in_valid/in_ready): in_action 0 adds or updates the parent of
// in_node_address; in_action 1 builds the route from in_node_address to the sink.
// Output channel (out_valid/out_ready): an add gives one transaction with the
// status; a route gives one transaction per path node, destination first, sink
// excluded, out_last on the final one, or a single error transaction.
// cfg_we/cfg_wdata write the sink address; write it only while the block is idle.
// Steps, from acceptance: an add passes the ADD step and returns its status.
// A route walks the table (one key match plus one parent read from the table
// memory per hop), passes a select step and then emits the path, for routes
// of up to 16 hops. The LOOK/CHECK hop loop of the microcode sets the rate.
// One item is processed at a time; a new one is taken while the last result
// still sits in the output register.
// Reset empties the table and sets the sink to 1. A stalled receiver holds the
// output register and the sequencer waits at its next result-producing step.
module parent_table_source_route_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptsr_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [ptsr_pkg::ADDR_W-1:0]    in_node_address,
  input  logic [ptsr_pkg::ADDR_W-1:0]    in_parent_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ptsr_pkg::STATUS_W-1:0]  out_status,
  output logic [ptsr_pkg::ADDR_W-1:0]    out_hop_node,
  output logic [ptsr_pkg::POS_W-1:0]     out_hop_position,
  output logic                           out_last
);

  localparam int TD = ptsr_pkg::TABLE_DEPTH;
  localparam int MH = ptsr_pkg::MAX_HOPS;

  ptsr_pkg::step_t                    upc_r;
  ptsr_pkg::step_t                    upc_nxt;
  ptsr_pkg::ctrl_t                    cw;
  logic                               go;
  logic                               cond_val;
  logic                               out_free;

  logic [ptsr_pkg::ADDR_W-1:0]        sink_r;
  logic [ptsr_pkg::TCNT_W-1:0]        count_r;
  logic [ptsr_pkg::ADDR_W-1:0]        key_r [TD];
  logic [ptsr_pkg::ADDR_W-1:0]        path_r [MH];
  logic [ptsr_pkg::ADDR_W-1:0]        cur_r;
  logic [ptsr_pkg::ADDR_W-1:0]        par_r;
  logic [ptsr_pkg::HCNT_W-1:0]        n_r;
  logic [ptsr_pkg::HIDX_W-1:0]        e_r;
  logic                               ok_r;

  logic [TD-1:0]                      match;
  logic                               hit;
  logic [ptsr_pkg::TIDX_W-1:0]        hit_idx;
  logic [ptsr_pkg::ADDR_W-1:0]        parent;
  logic                               on_path;
  logic                               broken;
  logic                               at_sink;
  logic                               at_limit;
  logic                               more;
  logic                               emit_last;
  logic                               add_null;
  logic                               add_full;
  logic                               add_new;

  logic                               ram_we;
  logic [ptsr_pkg::TIDX_W-1:0]        ram_waddr;

  logic                               out_valid_r;
  logic [ptsr_pkg::STATUS_W-1:0]      out_status_r;
  logic [ptsr_pkg::ADDR_W-1:0]        out_node_r;
  logic [ptsr_pkg::POS_W-1:0]         out_pos_r;
  logic                               out_last_r;
  logic                               out_load;
  ptsr_pkg::status_t                  status_nxt;
  logic [ptsr_pkg::ADDR_W-1:0]        node_nxt;
  logic [ptsr_pkg::POS_W-1:0]         pos_nxt;
  logic                               last_nxt;

  // Fetch the control word and decide whether the step can proceed
  always_comb begin
    cw       = ptsr_pkg::ucode(upc_r);
    out_free = !out_valid_r || out_ready;
    in_ready = cw.wait_in;
    go       = !(cw.wait_in && !in_valid) && !(cw.use_out && !out_free);
  end

  // Match the current node against all written keys
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TD; i++) begin
      match[i] = (ptsr_pkg::TCNT_W'(i) < count_r) && (key_r[i] == cur_r);
      if (match[i]) begin
        hit_idx = hit_idx | ptsr_pkg::TIDX_W'(i);
      end
    end
    hit = |match;
  end

  // Parent storage
  ptsr_ram #(
    .WIDTH (ptsr_pkg::ADDR_W),
    .DEPTH (TD)
  ) u_parents (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (par_r),
    .raddr (hit_idx),
    .rdata (parent)
  );

  // Add decisions
  always_comb begin
    add_null  = (cur_r == '0) || (par_r == '0);
    add_full  = !add_null && !hit && (count_r == ptsr_pkg::TCNT_W'(TD));
    add_new   = !add_null && !hit && !add_full;
    ram_we    = go && (cw.op == ptsr_pkg::OP_ADD) && !add_null && !add_full;
    ram_waddr = hit ? hit_idx : count_r[ptsr_pkg::TIDX_W-1:0];
  end

  // Loop check and walk termination
  always_comb begin
    on_path = 1'b0;
    for (int i = 0; i < MH; i++) begin
      if ((ptsr_pkg::HCNT_W'(i) < n_r) && (path_r[i] == parent)) begin
        on_path = 1'b1;
      end
    end
    broken    = (parent == '0) || on_path;
    at_sink   = (parent == sink_r);
    at_limit  = (n_r + ptsr_pkg::HCNT_W'(1)) == ptsr_pkg::HCNT_W'(MH);
    more      = !broken && !at_sink && !at_limit;
    emit_last = (ptsr_pkg::HCNT_W'(e_r) + ptsr_pkg::HCNT_W'(1)) == n_r;
  end

  // Branch condition
  always_comb begin
    case (cw.cond)
      ptsr_pkg::C_ALWAYS:    cond_val = 1'b1;
      ptsr_pkg::C_ACTION:    cond_val = in_action;
      ptsr_pkg::C_HIT:       cond_val = hit;
      ptsr_pkg::C_MORE:      cond_val = more;
      ptsr_pkg::C_OK:        cond_val = ok_r;
      ptsr_pkg::C_MORE_EMIT: cond_val = !emit_last;
      default:               cond_val = 1'b0;
    endcase
    upc_nxt = cond_val ? cw.tgt_t : cw.tgt_f;
  end

  // Result to load into the output register
  always_comb begin
    out_load   = 1'b0;
    status_nxt = ptsr_pkg::ST_OK;
    node_nxt   = '0;
    pos_nxt    = '0;
    last_nxt   = 1'b1;
    case (cw.op)
      ptsr_pkg::OP_ADD: begin
        out_load   = go;
        status_nxt = add_full ? ptsr_pkg::ST_FULL : ptsr_pkg::ST_OK;
      end
      ptsr_pkg::OP_LOOK: begin
        out_load   = go && !hit;
        status_nxt = ptsr_pkg::ST_BROKEN;
      end
      ptsr_pkg::OP_CHECK: begin
        out_load   = go && (broken || (!at_sink && at_limit));
        status_nxt = broken ? ptsr_pkg::ST_BROKEN : ptsr_pkg::ST_TOO_LONG;
      end
      ptsr_pkg::OP_EMIT: begin
        out_load = go;
        node_nxt = path_r[e_r];
        pos_nxt  = ptsr_pkg::POS_W'(e_r);
        last_nxt = emit_last;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control state: step counter, sink, fill count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ptsr_pkg::P_IDLE;
      sink_r      <= ptsr_pkg::SINK_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        sink_r <= cfg_wdata;
      end
      if (go) begin
        upc_r <= upc_nxt;
      end
      if (go && (cw.op == ptsr_pkg::OP_ADD) && add_new) begin
        count_r <= count_r + ptsr_pkg::TCNT_W'(1);
      end
      if (go && (cw.op == ptsr_pkg::OP_ACCEPT)) begin
        ok_r <= 1'b0;
      end else if (go && (cw.op == ptsr_pkg::OP_CHECK) && !broken && at_sink) begin
        ok_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (go) begin
      case (cw.op)
        ptsr_pkg::OP_ACCEPT: begin
          cur_r <= in_node_address;
          par_r <= in_parent_address;
          n_r   <= '0;
          e_r   <= '0;
        end
        ptsr_pkg::OP_ADD: begin
          if (add_new) begin
            key_r[count_r[ptsr_pkg::TIDX_W-1:0]] <= cur_r;
          end
        end
        ptsr_pkg::OP_LOOK: begin
          path_r[n_r[ptsr_pkg::HIDX_W-1:0]] <= cur_r;
        end
        ptsr_pkg::OP_CHECK: begin
          cur_r <= parent;
          n_r   <= n_r + ptsr_pkg::HCNT_W'(1);
        end
        ptsr_pkg::OP_EMIT: begin
          e_r <= e_r + ptsr_pkg::HIDX_W'(1);
        end
        default: begin
          e_r <= e_r;
        end
      endcase
    end
    if (out_load) begin
      out_status_r <= status_nxt;
      out_node_r   <= node_nxt;
      out_pos_r    <= pos_nxt;
      out_last_r   <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_hop_node     = out_node_r;
  assign out_hop_position = out_pos_r;
  assign out_last         = out_last_r;

endmodule
